// ===== rtl/spi_slave_frame_exchange_top_defines.svh =====
// Assertion macros shared by the SPI slave frame exchange RTL.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef SPI_SLAVE_FRAME_EXCHANGE_TOP_DEFINES_SVH
`define SPI_SLAVE_FRAME_EXCHANGE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define SSFE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define SSFE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssfe_pkg.sv =====
// Package for the SPI slave frame exchange: item modes, register indexes,
// frame marker bytes and mask reset values. Depends on nothing.
package ssfe_pkg;

    localparam int MASK_BITS = 35;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] FOOTER_BYTE = 8'h55;

    localparam logic [MASK_BITS-1:0] READ_MASK_RESET  = 35'h3FFFFFC00;
    localparam logic [MASK_BITS-1:0] WRITE_MASK_RESET = 35'h4000003FF;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_MASK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MASK = 1'b1;

    typedef enum logic [1:0] {
        MODE_SPI     = 2'd0,
        MODE_HOST_WR = 2'd1,
        MODE_HOST_RD = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

endpackage

// ===== rtl/spi_slave_frame_exchange_top.sv =====
// SPI slave frame exchange: receive/send frame memories, slave record table
// and the end-of-frame merge/rebuild sequencer. Depends on ssfe_pkg and
// spi_slave_frame_exchange_top_defines.svh.
//
// Usage
//   Input channel (s_*): one item per SPI byte (mode SPI) or per host access
//   (host write / host read). Result channel (m_*): exactly one result item
//   per input item, in order. Configuration port (cfg_*): write the read and
//   write byte masks while the block is idle; takes effect at once.
//   Result path: an SPI byte that does not end a frame, and every host access,
//   passes through the result state into the output register; the block
//   takes the next item at the same edge at which a ready receiver takes
//   the result, and takes no new item before its result is loaded.
//   The dummy byte after a frame starts the merge/rebuild sequencer, which
//   walks every frame byte once through a three-stage pipeline around the
//   record table, which has one write port and one read port.
//   Reset: a clearing pass walks the record table, one entry a cycle, over
//   all SLAVE_COUNT * FRAME_BYTES entries (280 by default), zeroing the send
//   frame on the way; s_ready stays low until it is over.
//   Stall: a result held by a low m_ready stays in the output register; the
//   block still accepts the next item and holds its result until the output
//   register is free.
module spi_slave_frame_exchange_top #(
    parameter int FRAME_BYTES = 35,
    parameter int SLAVE_COUNT = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input item channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [7:0]                      s_rx_byte,
    input  logic [2:0]                      s_slave_index,
    input  logic [5:0]                      s_byte_offset,
    input  logic [7:0]                      s_host_data,
    // result item channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_tx_byte,
    output logic                            m_frame_done,
    output logic                            m_frame_ok,
    output logic [15:0]                     m_error_count,
    output logic [7:0]                      m_read_data,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [ssfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssfe_pkg::MASK_BITS-1:0]  cfg_data
);

`include "spi_slave_frame_exchange_top_defines.svh"

    localparam int POS_W     = $clog2(FRAME_BYTES + 1);
    localparam int SEND_AW   = $clog2(FRAME_BYTES);
    localparam int TBL_DEPTH = SLAVE_COUNT * FRAME_BYTES;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int SLV_W     = (SLAVE_COUNT > 1) ? $clog2(SLAVE_COUNT) : 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FRAME,
        ST_RESULT
    } state_t;

    state_t                         state_reg;
    logic [TBL_AW-1:0]              clr_addr_reg;
    logic [POS_W-1:0]               byte_pos_reg;
    logic [SLV_W-1:0]               nss_reg;
    logic [SLV_W-1:0]               nss_next;
    logic [15:0]                    bad_cnt_reg;
    logic [ssfe_pkg::MASK_BITS-1:0] rmask_reg;
    logic [ssfe_pkg::MASK_BITS-1:0] wmask_reg;

    // frame check bytes, captured as they arrive
    logic [7:0]                     hdr_reg;
    logic [7:0]                     slv_reg;
    logic [7:0]                     ftr_reg;
    logic                           ok_reg;
    logic                           frame_ok_now;

    // item bookkeeping for the result
    ssfe_pkg::mode_t                mode_reg;
    logic                           in_range_reg;
    logic                           frame_end_reg;

    // merge/rebuild sequencer
    logic [POS_W-1:0]               k_reg;
    logic [TBL_AW-1:0]              dst_base_reg;
    logic [TBL_AW-1:0]              src_base_reg;
    logic                           same_slave_reg;
    logic                           s1_valid_reg;
    logic [SEND_AW-1:0]             s1_idx_reg;
    logic                           s2_valid_reg;
    logic [SEND_AW-1:0]             s2_idx_reg;
    logic                           s2_wbit_reg;
    logic                           s2_byp_reg;
    logic [7:0]                     s2_rx_reg;
    logic [ssfe_pkg::MASK_BITS-1:0] rd_shift;
    logic [ssfe_pkg::MASK_BITS-1:0] wr_shift;
    logic                           s1_merge;

    // memories and their ports
    logic [7:0]                     tbl_mem [TBL_DEPTH];
    logic [7:0]                     rx_mem [FRAME_BYTES + 1];
    logic [7:0]                     send_mem [FRAME_BYTES];
    logic                           tbl_we;
    logic                           tbl_re;
    logic [TBL_AW-1:0]              tbl_waddr;
    logic [TBL_AW-1:0]              tbl_raddr;
    logic [7:0]                     tbl_wdata;
    logic [7:0]                     tbl_rdata_reg;
    logic                           rx_we;
    logic [7:0]                     rx_rdata_reg;
    logic                           send_we;
    logic [SEND_AW-1:0]             send_waddr;
    logic [7:0]                     send_wdata;
    logic [7:0]                     send_rdata_reg;

    // output register
    logic                           m_valid_reg;
    logic [7:0]                     m_tx_byte_reg;
    logic                           m_frame_done_reg;
    logic                           m_frame_ok_reg;
    logic [15:0]                    m_error_count_reg;
    logic [7:0]                     m_read_data_reg;

    logic                           accept;
    logic                           host_in_range;
    logic [TBL_AW-1:0]              host_addr;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign host_in_range = (32'(s_slave_index) < SLAVE_COUNT) &&
                           (32'(s_byte_offset) < FRAME_BYTES);
    assign host_addr     = TBL_AW'(32'(s_slave_index) * FRAME_BYTES + 32'(s_byte_offset));

    assign frame_ok_now  = (hdr_reg == ssfe_pkg::HEADER_BYTE) &&
                           (32'(slv_reg) < SLAVE_COUNT) &&
                           (ftr_reg == ssfe_pkg::FOOTER_BYTE);

    assign nss_next      = (32'(nss_reg) == SLAVE_COUNT - 1) ? '0 : nss_reg + 1'b1;

    // mask bits past the mask width shift in as zero
    assign rd_shift      = rmask_reg >> s1_idx_reg;
    assign wr_shift      = wmask_reg >> s1_idx_reg;
    assign s1_merge      = ok_reg && rd_shift[0];

    assign rx_we         = accept && (s_mode == ssfe_pkg::MODE_SPI);

    // Route the record table and the send frame between the clearing
    // pass, host accesses and the sequencer stages.
    always_comb begin
        tbl_we     = 1'b0;
        tbl_re     = 1'b0;
        tbl_waddr  = host_addr;
        tbl_wdata  = s_host_data;
        tbl_raddr  = host_addr;
        send_we    = 1'b0;
        send_waddr = s2_idx_reg;
        send_wdata = s2_wbit_reg ? (s2_byp_reg ? s2_rx_reg : tbl_rdata_reg) : 8'd0;
        unique case (state_reg)
            ST_CLEAR: begin
                tbl_we     = 1'b1;
                tbl_waddr  = clr_addr_reg;
                tbl_wdata  = 8'd0;
                send_we    = (32'(clr_addr_reg) < FRAME_BYTES);
                send_waddr = SEND_AW'(clr_addr_reg);
                send_wdata = 8'd0;
            end
            ST_IDLE: begin
                tbl_we = accept && (s_mode == ssfe_pkg::MODE_HOST_WR) && host_in_range;
                tbl_re = accept;
            end
            ST_FRAME: begin
                // stage 1 merges the received byte and fetches the send source
                tbl_we    = s1_valid_reg && s1_merge;
                tbl_waddr = dst_base_reg + TBL_AW'(s1_idx_reg);
                tbl_wdata = rx_rdata_reg;
                tbl_raddr = src_base_reg + TBL_AW'(s1_idx_reg);
                tbl_re    = s1_valid_reg;
                // stage 2 writes the send frame
                send_we   = s2_valid_reg;
            end
            ST_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            tbl_rdata_reg <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem[byte_pos_reg] <= s_rx_byte;
        end
        rx_rdata_reg <= rx_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (send_we) begin
            send_mem[send_waddr] <= send_wdata;
        end
        if (accept) begin
            send_rdata_reg <= send_mem[SEND_AW'(byte_pos_reg)];
        end
    end

    // Sequencer, counters and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            byte_pos_reg <= '0;
            nss_reg      <= SLV_W'(1 % SLAVE_COUNT);
            bad_cnt_reg  <= 16'd0;
            rmask_reg    <= ssfe_pkg::READ_MASK_RESET;
            wmask_reg    <= ssfe_pkg::WRITE_MASK_RESET;
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                priority if (cfg_index == ssfe_pkg::CFG_READ_MASK) begin
                    rmask_reg <= cfg_data;
                end else if (cfg_index == ssfe_pkg::CFG_WRITE_MASK) begin
                    wmask_reg <= cfg_data;
                end
            end

            // drop a taken result unless a new one is loaded this cycle
            if (m_valid_reg && m_ready && state_reg != ST_RESULT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == TBL_AW'(TBL_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        mode_reg      <= ssfe_pkg::mode_t'(s_mode);
                        in_range_reg  <= host_in_range;
                        frame_end_reg <= 1'b0;
                        state_reg     <= ST_RESULT;
                        if (s_mode == ssfe_pkg::MODE_SPI) begin
                            if (byte_pos_reg == POS_W'(0)) begin
                                hdr_reg <= s_rx_byte;
                            end
                            if (byte_pos_reg == POS_W'(1)) begin
                                slv_reg <= s_rx_byte;
                            end
                            if (byte_pos_reg == POS_W'(FRAME_BYTES - 1)) begin
                                ftr_reg <= s_rx_byte;
                            end
                            if (byte_pos_reg == POS_W'(FRAME_BYTES)) begin
                                // dummy byte: check, count, start merge/rebuild
                                ok_reg         <= frame_ok_now;
                                if (!frame_ok_now) begin
                                    bad_cnt_reg <= bad_cnt_reg + 16'd1;
                                end
                                dst_base_reg   <= TBL_AW'(32'(slv_reg) * FRAME_BYTES);
                                src_base_reg   <= TBL_AW'(32'(nss_reg) * FRAME_BYTES);
                                same_slave_reg <= (32'(slv_reg) == 32'(nss_reg));
                                nss_reg        <= nss_next;
                                k_reg          <= '0;
                                frame_end_reg  <= 1'b1;
                                byte_pos_reg   <= '0;
                                state_reg      <= ST_FRAME;
                            end else begin
                                byte_pos_reg <= byte_pos_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_FRAME: begin
                    // stage 0: fetch the received byte
                    s1_valid_reg <= (k_reg < POS_W'(FRAME_BYTES));
                    if (k_reg < POS_W'(FRAME_BYTES)) begin
                        s1_idx_reg <= SEND_AW'(k_reg);
                        k_reg      <= k_reg + 1'b1;
                    end
                    // stage 1 to 2: hand over; forward a byte merged into the
                    // record that is also being sent
                    s2_valid_reg <= s1_valid_reg;
                    if (s1_valid_reg) begin
                        s2_idx_reg  <= s1_idx_reg;
                        s2_wbit_reg <= wr_shift[0];
                        s2_byp_reg  <= same_slave_reg && s1_merge;
                        s2_rx_reg   <= rx_rdata_reg;
                    end
                    if (k_reg == POS_W'(FRAME_BYTES) && !s1_valid_reg && !s2_valid_reg) begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    // hold the result until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_tx_byte_reg     <= (mode_reg == ssfe_pkg::MODE_SPI && !frame_end_reg)
                                             ? send_rdata_reg : 8'd0;
                        m_frame_done_reg  <= frame_end_reg;
                        m_frame_ok_reg    <= frame_end_reg && ok_reg;
                        m_error_count_reg <= bad_cnt_reg;
                        m_read_data_reg   <= (mode_reg == ssfe_pkg::MODE_HOST_RD && in_range_reg)
                                             ? tbl_rdata_reg : 8'd0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tx_byte     = m_tx_byte_reg;
    assign m_frame_done  = m_frame_done_reg;
    assign m_frame_ok    = m_frame_ok_reg;
    assign m_error_count = m_error_count_reg;
    assign m_read_data   = m_read_data_reg;

    `SSFE_ASSERT_IMP(a_pos_range, 1'b1, 32'(byte_pos_reg) <= FRAME_BYTES, "position past frame")
    `SSFE_ASSERT_IMP(a_nss_range, 1'b1, 32'(nss_reg) < SLAVE_COUNT, "send slave out of range")
    `SSFE_ASSERT_IMP(a_ok_needs_done, m_valid, !m_frame_ok || m_frame_done, "ok without frame end")
    `SSFE_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")
    `SSFE_ASSERT_IMP(a_err_step, bad_cnt_reg != $past(bad_cnt_reg), bad_cnt_reg == 16'($past(bad_cnt_reg) + 16'd1), "error count jumped")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for spi_slave_frame_exchange_top: directed host and frame items,
// then randomised frames, host accesses and mask settings under varied handshake idling.
// Depends on ssfe_pkg and the block's RTL only.
module testbench;
    import ssfe_pkg::*;

    localparam int FRAME_BYTES  = 35;
    localparam int SLAVE_COUNT  = 8;
    localparam int LIMIT_CYCLES = 500000;
    localparam int SETTLE       = 60;
    localparam int MAX_SHOWN    = 10;
    localparam logic [MASK_BITS-1:0] MASK_ALL = {MASK_BITS{1'b1}};

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  rx;
        logic [2:0]  slave;
        logic [5:0]  offset;
        logic [7:0]  hdata;
    } exchange_item_t;

    typedef struct packed {
        logic [7:0]  tx;
        logic        done;
        logic        ok;
        logic [15:0] errc;
        logic [7:0]  rdata;
    } exchange_result_t;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_HEADER,
        FRAME_BAD_FOOTER,
        FRAME_BAD_SLAVE
    } frame_kind_t;

    // Tracks the block's frame buffers and record table, predicts one result per
    // accepted item and checks results against them in order.
    class frame_exchange_scoreboard;
        bit [MASK_BITS-1:0] rd_mask;
        bit [MASK_BITS-1:0] wr_mask;
        bit [7:0]           rx_frame [FRAME_BYTES+1];
        bit [7:0]           tx_frame [FRAME_BYTES];
        bit [7:0]           records  [SLAVE_COUNT][FRAME_BYTES];
        int unsigned        pos;
        int unsigned        next_src;
        bit [15:0]          bad_frames;
        exchange_result_t   expected_q [$];
        int unsigned        failures;

        function new();
            rd_mask    = READ_MASK_RESET;
            wr_mask    = WRITE_MASK_RESET;
            pos        = 0;
            next_src   = 1 % SLAVE_COUNT;
            bad_frames = '0;
            failures   = 0;
            foreach (rx_frame[i]) rx_frame[i] = '0;
            foreach (tx_frame[i]) tx_frame[i] = '0;
            foreach (records[s, i]) records[s][i] = '0;
        endfunction

        function void set_mask(logic [CFG_IDX_W-1:0] idx, bit [MASK_BITS-1:0] value);
            if (idx == CFG_READ_MASK) begin
                rd_mask = value;
            end else if (idx == CFG_WRITE_MASK) begin
                wr_mask = value;
            end
        endfunction

        // Check the completed frame, merge it or count it bad, then rebuild the
        // send frame from the rotating slave's record.
        function bit close_frame();
            int unsigned slv;
            int unsigned src;
            bit          good;
            slv  = rx_frame[1];
            src  = next_src;
            good = slv < SLAVE_COUNT && rx_frame[0] == HEADER_BYTE &&
                   rx_frame[FRAME_BYTES-1] == FOOTER_BYTE;
            if (good) begin
                for (int i = 0; i < FRAME_BYTES; i++)
                    if (i < MASK_BITS && rd_mask[i]) records[slv][i] = rx_frame[i];
            end else begin
                bad_frames++;
            end
            for (int i = 0; i < FRAME_BYTES; i++)
                tx_frame[i] = (i < MASK_BITS && wr_mask[i]) ? records[src][i] : 8'h00;
            next_src = (src + 1 > SLAVE_COUNT - 1) ? 0 : src + 1;
            return good;
        endfunction

        function void note_item(exchange_item_t it);
            exchange_result_t exp;
            bit               in_range;
            exp      = '0;
            in_range = it.slave < SLAVE_COUNT && it.offset < FRAME_BYTES;
            case (it.mode)
                MODE_SPI: begin
                    if (pos > FRAME_BYTES) pos = 0;
                    rx_frame[pos] = it.rx;
                    if (pos < FRAME_BYTES) exp.tx = tx_frame[pos];
                    pos++;
                    if (pos > FRAME_BYTES) begin
                        exp.done = 1'b1;
                        exp.ok   = close_frame();
                        exp.tx   = 8'h00;
                        pos      = 0;
                    end
                end
                MODE_HOST_WR: begin
                    if (in_range) records[it.slave][it.offset] = it.hdata;
                end
                MODE_HOST_RD: begin
                    if (in_range) exp.rdata = records[it.slave][it.offset];
                end
                default: ;
            endcase
            exp.errc = bad_frames;
            expected_q.push_back(exp);
        endfunction

        function void check_result(exchange_result_t got);
            exchange_result_t exp;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display({"result with nothing expected: ",
                              "tx %0h done %0b ok %0b err %0d rd %0h"},
                             got.tx, got.done, got.ok, got.errc, got.rdata);
                return;
            end
            exp = expected_q.pop_front();
            if (got.tx !== exp.tx || got.done !== exp.done || got.ok !== exp.ok ||
                got.errc !== exp.errc || got.rdata !== exp.rdata) begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display({"mismatch (exp/act): tx %0h/%0h done %0b/%0b ok %0b/%0b ",
                              "err %0d/%0d rd %0h/%0h"},
                             exp.tx, got.tx, exp.done, got.done, exp.ok, got.ok,
                             exp.errc, got.errc, exp.rdata, got.rdata);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_mode;
    logic [7:0]           s_rx_byte;
    logic [2:0]           s_slave_index;
    logic [5:0]           s_byte_offset;
    logic [7:0]           s_host_data;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_tx_byte;
    logic                 m_frame_done;
    logic                 m_frame_ok;
    logic [15:0]          m_error_count;
    logic [7:0]           m_read_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_BITS-1:0] cfg_data;

    frame_exchange_scoreboard sb;
    int unsigned items_sent;
    int unsigned frame_pos;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    spi_slave_frame_exchange_top #(
        .FRAME_BYTES (FRAME_BYTES),
        .SLAVE_COUNT (SLAVE_COUNT)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_rx_byte     (s_rx_byte),
        .s_slave_index (s_slave_index),
        .s_byte_offset (s_byte_offset),
        .s_host_data   (s_host_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_frame_done  (m_frame_done),
        .m_frame_ok    (m_frame_ok),
        .m_error_count (m_error_count),
        .m_read_data   (m_read_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop: the slowest correct run stays far below this.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("status: fail");
        $finish;
    end

    // Result side: check at each edge where a result is taken, then pick the
    // next ready level; a stall percentage of zero keeps ready high throughout.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result('{m_tx_byte, m_frame_done, m_frame_ok,
                                  m_error_count, m_read_data});
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offer one item: idle first if the sender is idling, then hold valid and
    // payload until the edge that accepts the item. Always called at an edge.
    task automatic send_item(mode_t mode, logic [7:0] rx, logic [2:0] slave,
                             logic [5:0] offset, logic [7:0] hdata);
        int unsigned gap;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_rx_byte     <= rx;
        s_slave_index <= slave;
        s_byte_offset <= offset;
        s_host_data   <= hdata;
        do @(posedge aclk); while (!s_ready);
        sb.note_item('{mode, rx, slave, offset, hdata});
        items_sent++;
        if (mode == MODE_SPI) frame_pos = (frame_pos == FRAME_BYTES) ? 0 : frame_pos + 1;
    endtask

    task automatic send_spi(logic [7:0] rx);
        send_item(MODE_SPI, rx, 3'($urandom_range(7)), 6'($urandom_range(63)),
                  8'($urandom_range(255)));
    endtask

    task automatic send_host(mode_t mode, logic [2:0] slave, logic [5:0] offset,
                             logic [7:0] hdata);
        send_item(mode, 8'($urandom_range(255)), slave, offset, hdata);
    endtask

    // Random host access: mostly in-range offsets, sometimes any 6-bit value.
    task automatic send_host_random();
        int unsigned r;
        mode_t       mode;
        logic [5:0]  offset;
        r      = $urandom_range(99);
        mode   = (r < 45) ? MODE_HOST_WR : (r < 90) ? MODE_HOST_RD : MODE_NONE;
        offset = ($urandom_range(99) < 85) ? 6'($urandom_range(FRAME_BYTES-1))
                                           : 6'($urandom_range(63));
        send_host(mode, 3'($urandom_range(7)), offset, 8'($urandom_range(255)));
    endtask

    // One whole frame plus its dummy byte, aligned to a frame start; random
    // content with the marker bytes set or broken as the kind asks.
    task automatic send_frame(frame_kind_t kind, logic [7:0] target, bit mix_host);
        logic [7:0] b;
        while (frame_pos != 0) send_spi(8'($urandom_range(255)));
        for (int i = 0; i <= FRAME_BYTES; i++) begin
            b = 8'($urandom_range(255));
            if (i == 0) begin
                b = (kind == FRAME_BAD_HEADER) ? ((b == HEADER_BYTE) ? ~b : b) : HEADER_BYTE;
            end else if (i == 1) begin
                b = (kind == FRAME_BAD_SLAVE) ? 8'($urandom_range(255, SLAVE_COUNT)) : target;
            end else if (i == FRAME_BYTES - 1) begin
                b = (kind == FRAME_BAD_FOOTER) ? ((b == FOOTER_BYTE) ? ~b : b) : FOOTER_BYTE;
            end
            send_spi(b);
            if (mix_host && $urandom_range(99) < 8) send_host_random();
        end
    endtask

    // Drop valid and hold until every expected result is in, then settle.
    task automatic drain(int unsigned settle);
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_BITS-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_mask(idx, value);
    endtask

    task automatic run_phase(int unsigned s_pct, int unsigned r_pct, int unsigned quota);
        int unsigned start;
        int unsigned r;
        sender_idle_pct    = s_pct;
        receiver_stall_pct = r_pct;
        start = items_sent;
        while (items_sent - start < quota) begin
            r = $urandom_range(99);
            if (r < 68) begin
                send_frame(FRAME_GOOD, 8'($urandom_range(SLAVE_COUNT-1)), 1'b1);
            end else if (r < 80) begin
                send_frame(frame_kind_t'($urandom_range(3, 1)), 8'($urandom_range(255)), 1'b1);
            end else if (r < 91) begin
                repeat ($urandom_range(6, 1)) send_host_random();
            end else if (r < 98) begin
                // noise bytes that knock the frame alignment off
                repeat ($urandom_range(5, 1)) send_spi(8'($urandom_range(255)));
            end else begin
                drain(0);
            end
        end
        drain(SETTLE);
    endtask

    initial begin
        sb                 = new();
        items_sent         = 0;
        frame_pos          = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_mode             = MODE_NONE;
        s_rx_byte          = '0;
        s_slave_index      = '0;
        s_byte_offset      = '0;
        s_host_data        = '0;
        m_ready            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_READ_MASK;
        cfg_data           = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: record extremes, out-of-range host access, unused mode.
        send_host(MODE_HOST_RD, 3'd7, 6'd34, 8'h00);
        send_host(MODE_HOST_WR, 3'd7, 6'd34, 8'hFF);
        send_host(MODE_HOST_WR, 3'd0, 6'd0, 8'h00);
        send_host(MODE_HOST_WR, 3'd3, 6'd17, 8'hA5);
        send_host(MODE_HOST_RD, 3'd7, 6'd34, 8'h00);
        send_host(MODE_HOST_RD, 3'd0, 6'd0, 8'hFF);
        send_host(MODE_HOST_RD, 3'd3, 6'd17, 8'h00);
        send_host(MODE_HOST_WR, 3'd2, 6'd35, 8'h77);
        send_host(MODE_HOST_WR, 3'd5, 6'd63, 8'hFF);
        send_host(MODE_HOST_RD, 3'd2, 6'd35, 8'h00);
        send_host(MODE_HOST_RD, 3'd5, 6'd63, 8'h00);
        send_item(MODE_NONE, 8'hFF, 3'd7, 6'd63, 8'hFF);
        // First good frame targets slave one, which is also the next to be sent,
        // so the rebuilt send frame must carry the bytes just merged.
        send_frame(FRAME_GOOD, 8'd1, 1'b0);
        // A host write now must not reach the send frame already built.
        send_host(MODE_HOST_WR, 3'd1, 6'd34, 8'h12);
        send_frame(FRAME_BAD_HEADER, 8'd2, 1'b0);
        send_frame(FRAME_BAD_FOOTER, 8'd0, 1'b0);
        send_frame(FRAME_BAD_SLAVE, 8'd0, 1'b0);
        send_host(MODE_HOST_RD, 3'd1, 6'd34, 8'h00);
        drain(SETTLE);

        // Random phases, each with its own mask setting and idling pattern.
        run_phase(0, 0, 160);
        write_reg(CFG_READ_MASK, MASK_ALL);
        write_reg(CFG_WRITE_MASK, MASK_ALL);
        run_phase(61, 0, 160);
        write_reg(CFG_READ_MASK, '0);
        write_reg(CFG_WRITE_MASK, '0);
        run_phase(0, 61, 160);
        write_reg(CFG_READ_MASK, {3'($urandom_range(7)), 32'($urandom)});
        write_reg(CFG_WRITE_MASK, {3'($urandom_range(7)), 32'($urandom)});
        run_phase(17, 17, 160);
        write_reg(CFG_READ_MASK, MASK_ALL);
        write_reg(CFG_WRITE_MASK, {3'($urandom_range(7)), 32'($urandom)});
        run_phase(61, 61, 160);
        write_reg(CFG_READ_MASK, READ_MASK_RESET);
        write_reg(CFG_WRITE_MASK, WRITE_MASK_RESET);
        run_phase(0, 61, 160);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/ssfe_pkg.sv
rtl/spi_slave_frame_exchange_top.sv
test/testbench.sv
